// ===== sv/lhash_pkg.sv =====
// Shared types and codes for the linear-probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package lhash_pkg;

    localparam int KEY_W      = 20;
    localparam int HANDLE_W   = 16;
    localparam int SIZE_W     = 11;
    localparam int OUT_SLOT_W = 10;

    // remainder unit: bits of the key retired per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] KIND_INSERT    = 2'd0;
    localparam logic [1:0] KIND_LOOKUP    = 2'd1;
    localparam logic [1:0] KIND_ATTENDED  = 2'd2;
    localparam logic [1:0] KIND_SCHEDULED = 2'd3;

    localparam logic [1:0] RC_DONE      = 2'd0;
    localparam logic [1:0] RC_NOT_FOUND = 2'd1;
    localparam logic [1:0] RC_FULL      = 2'd2;

    localparam logic [1:0] STAT_WAITING   = 2'd0;
    localparam logic [1:0] STAT_ATTENDED  = 2'd1;
    localparam logic [1:0] STAT_SCHEDULED = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    id;
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          status;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== sv/lhash_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lhash_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over one slot RAM.
//
// Usage: requests enter on the in_valid/in_ready channel (kind, key_id,
// auto_id, record_handle), one word per request, and each gives exactly one
// result word on out_valid/out_ready. cfg_valid/cfg_data writes table_size;
// write it only while no request is in flight.
// Flow: after acceptance, ST_DIV computes the home slot as id modulo the
// live size, 4 key bits per cycle, then ST_PROBE reads the slots in turn,
// since the slot RAM gives one read per cycle with registered data.
// A request probes from 1 up to the live size slots; the next request is
// accepted only once the earlier one has loaded its result word.
// Reset: a clearing pass writes every RAM slot empty with in_ready low;
// table_size returns to 1024 and the entry count to zero.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, and that request holds in its last probe until the
// receiver takes the earlier word.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lhash_pkg::SIZE_W-1:0]     cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       kind,
    input  wire logic [lhash_pkg::KEY_W-1:0]      key_id,
    input  wire logic                             auto_id,
    input  wire logic [lhash_pkg::HANDLE_W-1:0]   record_handle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [1:0]                       result_code,
    output logic      [lhash_pkg::KEY_W-1:0]      used_id,
    output logic      [lhash_pkg::OUT_SLOT_W-1:0] slot_index,
    output logic      [lhash_pkg::HANDLE_W-1:0]   found_handle,
    output logic      [1:0]                       found_status
);

    import lhash_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int LIVE_W  = SLOT_W + 1;
    localparam int ENTRY_W = $bits(slot_entry_t);

    state_t                 state_reg, state_next;
    logic [SIZE_W-1:0]      size_reg;
    logic [SIZE_W-1:0]      count_reg, count_next;
    logic [1:0]             kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic [KEY_W-1:0]       q_reg, q_next;
    logic [LIVE_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [LIVE_W-1:0]      n_reg, n_next;
    logic [SLOT_W-1:0]      clr_reg, clr_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             code_reg, code_next;
    logic [KEY_W-1:0]       used_reg, used_next;
    logic [SLOT_W-1:0]      oslot_reg, oslot_next;
    logic [HANDLE_W-1:0]    ohandle_reg, ohandle_next;
    logic [1:0]             ostatus_reg, ostatus_next;

    logic [LIVE_W-1:0]      live_size;
    logic [LIVE_W:0]        div_trial;
    logic [LIVE_W-1:0]      div_rem;
    logic [KEY_W-1:0]       div_q;
    logic [LIVE_W-1:0]      idx_inc;
    logic [SLOT_W-1:0]      idx_wrap;
    logic                   last_probe;
    logic                   out_free;
    logic [1:0]             new_status;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    slot_entry_t            ram_wentry;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;
    slot_entry_t            rd_entry;

    lhash_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ram_wentry)),
        .re    (ram_re),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign rd_entry = slot_entry_t'(ram_rdata);

    // clamp the configured size to 1..TABLE_DEPTH
    always_comb
    begin
        if (size_reg == '0)
        begin
            live_size = LIVE_W'(1);
        end
        else if (32'(size_reg) > TABLE_DEPTH)
        begin
            live_size = LIVE_W'(TABLE_DEPTH);
        end
        else
        begin
            live_size = LIVE_W'(size_reg);
        end
    end

    // restoring remainder, DIV_BITS key bits per cycle
    always_comb
    begin
        div_rem = rem_reg;
        div_q   = q_reg;
        div_trial = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_trial = {div_rem, div_q[KEY_W-1]};
            div_q     = {div_q[KEY_W-2:0], 1'b0};
            if (div_trial >= {1'b0, live_size})
            begin
                div_trial = div_trial - {1'b0, live_size};
            end
            div_rem = div_trial[LIVE_W-1:0];
        end
    end

    assign idx_inc    = {1'b0, idx_reg} + LIVE_W'(1);
    assign idx_wrap   = (idx_inc >= live_size) ? '0 : idx_inc[SLOT_W-1:0];
    assign last_probe = (n_reg + LIVE_W'(1)) == live_size;
    assign out_free   = !out_valid_reg || out_ready;
    assign new_status = (kind_reg == KIND_SCHEDULED) ? STAT_SCHEDULED : STAT_ATTENDED;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_next      = code_reg;
        used_next      = used_reg;
        oslot_next     = oslot_reg;
        ohandle_next   = ohandle_reg;
        ostatus_next   = ostatus_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wentry     = rd_entry;
        ram_re         = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clr_reg;
                ram_wentry = '0;
                clr_next   = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next   = kind;
                    handle_next = record_handle;
                    if (kind == KIND_INSERT && auto_id)
                    begin
                        key_next = KEY_W'(count_reg) + KEY_W'(1);
                    end
                    else
                    begin
                        key_next = key_id;
                    end
                    q_next     = key_next;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                q_next    = div_q;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    // issue the read of the home slot
                    idx_next   = div_rem[SLOT_W-1:0];
                    n_next     = '0;
                    ram_re     = 1'b1;
                    state_next = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                priority if (kind_reg == KIND_INSERT && !rd_entry.valid)
                begin
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        ram_wentry     = '{valid: 1'b1, id: key_reg,
                                           handle: handle_reg, status: STAT_WAITING};
                        count_next     = count_reg + SIZE_W'(1);
                        out_valid_next = 1'b1;
                        code_next      = RC_DONE;
                        used_next      = key_reg;
                        oslot_next     = idx_reg;
                        ohandle_next   = handle_reg;
                        ostatus_next   = STAT_WAITING;
                        state_next     = ST_IDLE;
                    end
                end
                else if (kind_reg != KIND_INSERT && rd_entry.valid
                         && rd_entry.id == key_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        code_next      = RC_DONE;
                        used_next      = key_reg;
                        oslot_next     = idx_reg;
                        ohandle_next   = rd_entry.handle;
                        ostatus_next   = rd_entry.status;
                        if (kind_reg != KIND_LOOKUP)
                        begin
                            ram_we            = 1'b1;
                            ram_wentry.status = new_status;
                            ostatus_next      = new_status;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if ((kind_reg != KIND_INSERT && !rd_entry.valid) || last_probe)
                begin
                    // empty slot on a search, or a full lap: fail
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        code_next      = (kind_reg == KIND_INSERT) ? RC_FULL : RC_NOT_FOUND;
                        used_next      = key_reg;
                        oslot_next     = '0;
                        ohandle_next   = '0;
                        ostatus_next   = STAT_WAITING;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // advance to the next slot, wrapping at the live size
                    idx_next = idx_wrap;
                    n_next   = n_reg + LIVE_W'(1);
                    ram_re   = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            size_reg      <= SIZE_W'(1024);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        code_reg    <= code_next;
        used_reg    <= used_next;
        oslot_reg   <= oslot_next;
        ohandle_reg <= ohandle_next;
        ostatus_reg <= ostatus_next;
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign result_code  = code_reg;
    assign used_id      = used_reg;
    assign slot_index   = OUT_SLOT_W'(oslot_reg);
    assign found_handle = ohandle_reg;
    assign found_status = ostatus_reg;

`ifndef NO_ASSERTIONS
    // a new result word appears only at the end of a probe
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PROBE))
    else $error("result appeared outside a probe");

    // a failed request reports no slot, handle or status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_code != RC_DONE) |->
            (slot_index == '0 && found_handle == '0 && found_status == STAT_WAITING))
    else $error("failed request carries slot data");

    // the probe pointer stays inside the live part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> ({1'b0, idx_reg} < live_size))
    else $error("probe index beyond table size");

    // the entry count moves only when an insert completes
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg == ST_PROBE) && $past(kind_reg == KIND_INSERT)))
    else $error("entry count changed outside an insert");
`endif

endmodule

`default_nettype wire

// ===== verif/linear_probe_hash_table_test.sv =====
// Self-checking testbench for linear_probe_hash_table: directed and random requests.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

    import lhash_pkg::*;

    localparam int MAX_SLOTS = 1024;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_W-1:0]    key;
        logic                auto_sel;
        logic [HANDLE_W-1:0] handle;
    } hash_req_t;

    typedef struct packed {
        logic [1:0]            code;
        logic [KEY_W-1:0]      id;
        logic [OUT_SLOT_W-1:0] slot;
        logic [HANDLE_W-1:0]   handle;
        logic [1:0]            status;
    } hash_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            kind = KIND_INSERT;
    logic [KEY_W-1:0]      key_id = '0;
    logic                  auto_id = 1'b0;
    logic [HANDLE_W-1:0]   record_handle = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            result_code;
    logic [KEY_W-1:0]      used_id;
    logic [OUT_SLOT_W-1:0] slot_index;
    logic [HANDLE_W-1:0]   found_handle;
    logic [1:0]            found_status;

    // shadow copy of the table
    bit                  tbl_used   [MAX_SLOTS];
    logic [KEY_W-1:0]    tbl_id     [MAX_SLOTS];
    logic [HANDLE_W-1:0] tbl_handle [MAX_SLOTS];
    logic [1:0]          tbl_status [MAX_SLOTS];
    logic [SIZE_W-1:0]   tbl_count = '0;
    logic [SIZE_W-1:0]   tbl_size = SIZE_W'(MAX_SLOTS);

    hash_req_t   pending_reqs [$];
    hash_reply_t replies_due [$];
    int unsigned id_pool [$];

    hash_req_t   next_req;
    hash_req_t   took;
    hash_reply_t seen;
    hash_reply_t want;
    int          ops_open = 0;
    int          hold_in = 0;
    int          hold_out = 0;
    bit          calm = 1'b0;
    int          fault_count = 0;
    int          reqs_sent = 0;
    int          sizes_set = 0;
    int          n_done = 0;
    int          n_missing = 0;
    int          n_full = 0;
    int          phase_sizes [12] = '{1, 2, 5, 16, 1024, 37, 3, 100, 1023, 64, 511, 1024};

    linear_probe_hash_table #(
        .TABLE_DEPTH(MAX_SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key_id       (key_id),
        .auto_id      (auto_id),
        .record_handle(record_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_code  (result_code),
        .used_id      (used_id),
        .slot_index   (slot_index),
        .found_handle (found_handle),
        .found_status (found_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int live_span();
        if (tbl_size == 0)
        begin
            return 1;
        end
        if (tbl_size > MAX_SLOTS)
        begin
            return MAX_SLOTS;
        end
        return int'(tbl_size);
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(3, 0));
    endfunction

    // Apply one request to the shadow table and return the word it should produce.
    function automatic hash_reply_t hash_table_apply(input hash_req_t r);
        hash_reply_t rep;
        int          span;
        int          pos;
        int          n;
        bit          hit;
        bit          stop;
        rep = '0;
        rep.code = RC_DONE;
        rep.id = r.key;
        span = live_span();
        hit = 1'b0;
        stop = 1'b0;
        n = 0;
        if (r.kind == KIND_INSERT)
        begin
            if (r.auto_sel)
            begin
                rep.id = KEY_W'(tbl_count) + 1'b1;
            end
            pos = int'(rep.id) % span;
            while (!hit && n < span)
            begin
                if (!tbl_used[pos])
                begin
                    hit = 1'b1;
                end
                else
                begin
                    pos = (pos + 1 >= span) ? 0 : pos + 1;
                    n++;
                end
            end
            if (hit)
            begin
                tbl_used[pos] = 1'b1;
                tbl_id[pos] = rep.id;
                tbl_handle[pos] = r.handle;
                tbl_status[pos] = STAT_WAITING;
                tbl_count = tbl_count + 1'b1;
                rep.slot = OUT_SLOT_W'(pos);
                rep.handle = r.handle;
                rep.status = STAT_WAITING;
            end
            else
            begin
                rep.code = RC_FULL;
            end
        end
        else
        begin
            pos = int'(r.key) % span;
            while (!stop && n < span)
            begin
                if (!tbl_used[pos])
                begin
                    stop = 1'b1;
                end
                else if (tbl_id[pos] == r.key)
                begin
                    hit = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    pos = (pos + 1 >= span) ? 0 : pos + 1;
                    n++;
                end
            end
            if (hit)
            begin
                if (r.kind == KIND_ATTENDED)
                begin
                    tbl_status[pos] = STAT_ATTENDED;
                end
                else if (r.kind == KIND_SCHEDULED)
                begin
                    tbl_status[pos] = STAT_SCHEDULED;
                end
                rep.slot = OUT_SLOT_W'(pos);
                rep.handle = tbl_handle[pos];
                rep.status = tbl_status[pos];
            end
            else
            begin
                rep.code = RC_NOT_FOUND;
            end
        end
        return rep;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hold_in = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                took = {kind, key_id, auto_id, record_handle};
                replies_due.push_back(hash_table_apply(took));
                reqs_sent++;
                hold_in = draw_wait();
            end
            if (!in_valid || in_ready)
            begin
                if (hold_in != 0)
                begin
                    hold_in--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    kind <= next_req.kind;
                    key_id <= next_req.key;
                    auto_id <= next_req.auto_sel;
                    record_handle <= next_req.handle;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_out = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {result_code, used_id, slot_index, found_handle, found_status};
                if (replies_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("%0t: result word with nothing expected: code %0d id %h",
                                 $realtime, seen.code, seen.id);
                    end
                end
                else
                begin
                    want = replies_due.pop_front();
                    ops_open--;
                    case (want.code)
                        RC_DONE:      n_done++;
                        RC_NOT_FOUND: n_missing++;
                        default:      n_full++;
                    endcase
                    if (seen.code !== want.code || seen.id !== want.id
                        || seen.slot !== want.slot || seen.handle !== want.handle
                        || seen.status !== want.status)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("%0t: mismatch code %0d/%0d id %h/%h slot %0d/%0d",
                                     $realtime, want.code, seen.code, want.id, seen.id,
                                     want.slot, seen.slot);
                            $display("    handle %h/%h status %0d/%0d (expected/actual)",
                                     want.handle, seen.handle, want.status, seen.status);
                        end
                    end
                end
                hold_out = draw_wait();
            end
            else if (hold_out != 0)
            begin
                hold_out--;
            end
            out_ready <= (hold_out == 0);
        end
    end

    task automatic ask(input logic [1:0] k, input logic [KEY_W-1:0] id, input logic a,
                       input logic [HANDLE_W-1:0] h);
        pending_reqs.push_back(hash_req_t'{k, id, a, h});
        ops_open++;
    endtask

    task automatic wait_idle();
        while (ops_open != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_size = v;
        sizes_set++;
    endtask

    task automatic refill_pool();
        id_pool.delete();
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            if (tbl_used[s])
            begin
                id_pool.push_back(tbl_id[s]);
            end
        end
    endtask

    task automatic queue_random_op(input int span);
        hash_req_t   r;
        int          roll;
        int unsigned base;
        roll = $urandom_range(99, 0);
        r.handle = HANDLE_W'($urandom);
        r.auto_sel = 1'($urandom_range(1, 0));
        r.key = KEY_W'($urandom);
        base = (id_pool.size() != 0) ? id_pool[$urandom_range(id_pool.size() - 1, 0)]
                                     : $urandom;
        if (roll < 40)
        begin
            r.kind = KIND_INSERT;
            r.auto_sel = ($urandom_range(3, 0) == 0);
            case ($urandom_range(2, 0))
                0: ;
                // land on an occupied chain, or duplicate a stored id
                1: r.key = KEY_W'(base + span * $urandom_range(3, 0));
                default: r.key = KEY_W'($urandom_range(4 * span, 0));
            endcase
            if (!r.auto_sel)
            begin
                id_pool.push_back(r.key);
            end
        end
        else
        begin
            r.kind = (roll < 70) ? KIND_LOOKUP : (roll < 85) ? KIND_ATTENDED : KIND_SCHEDULED;
            if ($urandom_range(3, 0) != 0)
            begin
                r.key = KEY_W'(base);
            end
        end
        ask(r.kind, r.key, r.auto_sel, r.handle);
    endtask

    task automatic run_phase(input int sz, input int count, input bit quiet);
        int span;
        write_size(SIZE_W'(sz));
        calm = quiet;
        span = live_span();
        refill_pool();
        for (int i = 0; i < count; i++)
        begin
            // hold the sender halfway until every word has come back
            if (i == count / 2)
            begin
                wait_idle();
                refill_pool();
            end
            queue_random_op(span);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // default size: extremes, duplicates, collisions, misses
        ask(KIND_INSERT, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_INSERT, 20'hFFFFF, 1'b0, 16'hFFFF);
        ask(KIND_INSERT, 20'hABCDE, 1'b1, 16'h1234);
        ask(KIND_INSERT, 20'h00000, 1'b0, 16'h5555);
        ask(KIND_INSERT, 20'd1024, 1'b0, 16'h00AA);
        ask(KIND_LOOKUP, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_LOOKUP, 20'd1024, 1'b1, 16'hFFFF);
        ask(KIND_LOOKUP, 20'd3, 1'b0, 16'h0000);
        ask(KIND_ATTENDED, 20'hFFFFF, 1'b0, 16'h0000);
        ask(KIND_SCHEDULED, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_LOOKUP, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_LOOKUP, 20'd12345, 1'b0, 16'h0000);
        ask(KIND_ATTENDED, 20'h54321, 1'b0, 16'h0000);
        ask(KIND_SCHEDULED, 20'h00777, 1'b0, 16'h0000);

        // size zero acts as one slot, already taken
        write_size('0);
        ask(KIND_INSERT, 20'd5, 1'b0, 16'h0BAD);
        ask(KIND_INSERT, 20'd0, 1'b1, 16'h0BAD);
        ask(KIND_LOOKUP, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_ATTENDED, 20'h00000, 1'b0, 16'h0000);
        ask(KIND_LOOKUP, 20'd1, 1'b0, 16'h0000);

        // oversize clamps to the full table; probe wraps from the last slot
        write_size(SIZE_W'(2047));
        ask(KIND_LOOKUP, 20'hFFFFF, 1'b0, 16'h0000);
        ask(KIND_INSERT, 20'd2047, 1'b0, 16'h0001);
        ask(KIND_LOOKUP, 20'd2047, 1'b0, 16'h0000);
        ask(KIND_SCHEDULED, 20'd1024, 1'b0, 16'h0000);

        foreach (phase_sizes[p])
        begin
            run_phase(phase_sizes[p], 86, (p % 4 == 3));
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            fault_count++;
        end
        $display("Ran %0d requests across %0d size writes, sizes 0 to 2047.",
                 reqs_sent, sizes_set);
        $display("Replies: %0d done, %0d id not found, %0d table full.",
                 n_done, n_missing, n_full);
        if (fault_count == 0)
        begin
            $display("linear_probe_hash_table_test: clean");
        end
        else
        begin
            $display("linear_probe_hash_table_test: errors");
        end
        $finish;
    end

    // several times the slowest legal run: every request probing a full table
    initial
    begin
        #60_000_000;
        $display("linear_probe_hash_table_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lhash_pkg.sv
sv/lhash_ram.sv
sv/linear_probe_hash_table.sv
verif/linear_probe_hash_table_test.sv
